FILE: design/mac_learning_table_with_aging_macros.svh
// Assertion helpers for the table controller RTL
`ifndef MAC_LEARNING_TABLE_WITH_AGING_MACROS_SVH
`define MAC_LEARNING_TABLE_WITH_AGING_MACROS_SVH

// Checked only while out of reset
`define MLT_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define MLT_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/mlt_pkg.sv
package mlt_pkg;

	// Command codes
	localparam logic [1:0] CMD_LEARN  = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_AGE    = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_ZERO     = 2'd3;

	// Field widths
	localparam int MAC_W   = 48;
	localparam int PORT_W  = 8;
	localparam int STAMP_W = 32;
	localparam int AGED_W  = 11;
	localparam int SLOT_W  = MAC_W + PORT_W + STAMP_W;
	localparam logic [AGED_W-1:0] AGED_MAX = {AGED_W{1'b1}};

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;    // capture input item
		logic rd_en;      // read a bucket row
		logic use_row;    // address from row counter, else low bits of mac
		logic commit;     // finish learn/lookup/delete, load result
		logic sweep_step; // age one row, accumulate count
		logic acc_clr;    // clear aged accumulator
		logic emit_sweep; // load sweep result
		logic clr_wr;     // write zero row during clearing pass
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic       out_valid;
		logic [1:0] command;
	} stat_t;

endpackage

FILE: design/mac_learning_table_with_aging.sv
// Channel | Dir | Signals                  | Contents
// s       | in  | s_tvalid/tready/tdata/tuser | command on tuser, mac/port/now on tdata
// m       | out | m_tvalid/tready/tdata/tuser | status on tuser, found_port/aged_count on tdata
// cfg     | in  | cfg_we, cfg_wdata        | aging_time
//
// Learn, lookup and delete run as capture, bucket read, modify and write back.
// An age sweep runs capture, dispatch, a read and then a write of each bucket row
// through the memory, and the finish step.
// After reset a clearing pass zeroes every bucket row; no item is taken then.
// A result waits in the output register; a full register stalls only the finish step.
// BUCKETS must be a power of two; the bucket is the low bits of the mac.
module mac_learning_table_with_aging #(
	parameter int BUCKETS = 256,
	parameter int WAYS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // mac[47:0], port[55:48], now[87:56]
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // found_port[7:0], aged_count[18:8], zero pad
	output logic [1:0]  m_tuser,  // status[1:0]
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int BW = $clog2(BUCKETS);

	mlt_pkg::cmd_t  cmd;
	mlt_pkg::stat_t stat;
	logic [BW-1:0]  row;
	logic [7:0]     fport;
	logic [10:0]    aged;

	mlt_ctrl #(.BUCKETS(BUCKETS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd),
		.row       (row)
	);

	mlt_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.row        (row),
		.stat       (stat),
		.in_command (s_tuser),
		.in_mac     (s_tdata[47:0]),
		.in_port    (s_tdata[55:48]),
		.in_now     (s_tdata[87:56]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (m_tuser),
		.out_port   (fport),
		.out_aged   (aged)
	);

	assign m_tdata = {5'd0, aged, fport};

endmodule

FILE: design/mlt_ctrl.sv
`include "mac_learning_table_with_aging_macros.svh"

module mlt_ctrl #(
	parameter int BUCKETS = 256,
	localparam int BW = $clog2(BUCKETS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	input  mlt_pkg::stat_t      stat,
	output mlt_pkg::cmd_t       cmd,
	output logic [BW-1:0]       row
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_RD     = 3'd2;
	localparam logic [2:0] S_OP     = 3'd3;
	localparam logic [2:0] S_SW_RD  = 3'd4;
	localparam logic [2:0] S_SW_OP  = 3'd5;
	localparam logic [2:0] S_SW_END = 3'd6;

	localparam logic [BW-1:0] ROW_LAST = BW'(BUCKETS - 1);

	logic [2:0]    state_q, state_d;
	logic [BW-1:0] row_q, row_d;
	logic          out_free;

	assign out_free = !stat.out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign row      = row_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		row_d   = row_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.use_row = 1'b1;
				row_d       = row_q + 1'b1;
				if (row_q == ROW_LAST) begin
					row_d   = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.acc_clr = 1'b1;
					row_d       = '0;
					state_d     = S_RD;
				end
			end
			S_RD: begin
				if (stat.command == mlt_pkg::CMD_AGE) begin
					state_d = S_SW_RD;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_OP;
				end
			end
			S_OP: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SW_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.use_row = 1'b1;
				state_d     = S_SW_OP;
			end
			S_SW_OP: begin
				cmd.sweep_step = 1'b1;
				if (row_q == ROW_LAST) begin
					state_d = S_SW_END;
				end else begin
					row_d   = row_q + 1'b1;
					state_d = S_SW_RD;
				end
			end
			S_SW_END: begin
				if (out_free) begin
					cmd.emit_sweep = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
		end
	end

	`MLT_ASSERT_ALWAYS(a_clear_blocks, clk, (state_q == S_CLEAR) |-> !in_ready, "item taken during clearing")
	`MLT_ASSERT(a_emit_room, clk, arst_n, (cmd.commit || cmd.emit_sweep) |-> out_free, "result overwrites pending result")
	`MLT_ASSERT(a_accept_next, clk, arst_n, (in_valid && in_ready) |=> (state_q == S_RD), "accepted item not started")

endmodule

FILE: design/mlt_dp.sv
module mlt_dp #(
	parameter int BUCKETS = 256,
	parameter int WAYS = 4,
	localparam int BW = $clog2(BUCKETS),
	localparam int ROW_W = WAYS * mlt_pkg::SLOT_W,
	localparam int CW = $clog2(WAYS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mlt_pkg::cmd_t                 cmd,
	input  logic [BW-1:0]                 row,
	output mlt_pkg::stat_t                stat,
	input  logic [1:0]                    in_command,
	input  logic [mlt_pkg::MAC_W-1:0]     in_mac,
	input  logic [mlt_pkg::PORT_W-1:0]    in_port,
	input  logic [mlt_pkg::STAMP_W-1:0]   in_now,
	input  logic                          cfg_we,
	input  logic [mlt_pkg::STAMP_W-1:0]   cfg_wdata,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [1:0]                    out_status,
	output logic [mlt_pkg::PORT_W-1:0]    out_port,
	output logic [mlt_pkg::AGED_W-1:0]    out_aged
);

	localparam int MW = mlt_pkg::MAC_W;
	localparam int PW = mlt_pkg::PORT_W;
	localparam int TW = mlt_pkg::STAMP_W;
	localparam int SW = mlt_pkg::SLOT_W;

	logic [ROW_W-1:0] mem [BUCKETS];
	logic [ROW_W-1:0] rdata_q;
	logic [BW-1:0]    waddr_q;

	logic [1:0]    command_q;
	logic [MW-1:0] mac_q;
	logic [PW-1:0] port_q;
	logic [TW-1:0] now_q;
	logic [TW-1:0] aging_q;
	logic [mlt_pkg::AGED_W-1:0] aged_q;

	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [PW-1:0]         fport_q;
	logic [mlt_pkg::AGED_W-1:0] aged_out_q;

	logic [BW-1:0]    raddr;
	logic [WAYS-1:0]  hit_v, free_v, old_v;
	logic             hit_any, free_any;
	logic [ROW_W-1:0] op_row, age_row;
	logic             op_we;
	logic [1:0]       op_status;
	logic [PW-1:0]    op_port;
	logic [CW-1:0]    old_cnt;
	logic [mlt_pkg::AGED_W:0] aged_sum;

	assign stat.out_valid = out_valid_q;
	assign stat.command   = command_q;
	assign raddr = cmd.use_row ? row : mac_q[BW-1:0];

	// Input capture and aging register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_q <= TW'(300);
		end else if (cfg_we) begin
			aging_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			command_q <= in_command;
			mac_q     <= in_mac;
			port_q    <= in_port;
			now_q     <= in_now;
		end
	end

	// Per-way match, free and expiry flags
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hit_v[w]  = (rdata_q[w*SW +: MW] == mac_q);
			free_v[w] = (rdata_q[w*SW +: MW] == '0);
			old_v[w]  = !free_v[w] &&
				((now_q - rdata_q[w*SW+MW+PW +: TW]) > aging_q);
		end
	end

	// Learn, lookup, delete row update
	always_comb begin
		logic done;
		done      = 1'b0;
		hit_any   = |hit_v;
		free_any  = |free_v;
		op_row    = rdata_q;
		op_we     = 1'b0;
		op_status = mlt_pkg::ST_OK;
		op_port   = '0;
		if (mac_q == '0) begin
			op_status = mlt_pkg::ST_ZERO;
		end else if (command_q == mlt_pkg::CMD_LEARN) begin
			if (!hit_any && !free_any) begin
				op_status = mlt_pkg::ST_FULL;
			end
			for (int w = 0; w < WAYS; w++) begin
				if (!done && (hit_v[w] || (!hit_any && free_v[w]))) begin
					done = 1'b1;
					op_we = 1'b1;
					op_row[w*SW +: SW] = {now_q, port_q, mac_q};
				end
			end
		end else if (!hit_any) begin
			op_status = mlt_pkg::ST_NOTFOUND;
		end else begin
			for (int w = 0; w < WAYS; w++) begin
				if (!done && hit_v[w]) begin
					done  = 1'b1;
					op_we = 1'b1;
					if (command_q == mlt_pkg::CMD_LOOKUP) begin
						op_port = rdata_q[w*SW+MW +: PW];
						op_row[w*SW+MW+PW +: TW] = now_q;
					end else begin
						op_row[w*SW +: SW] = '0;
					end
				end
			end
		end
	end

	// Aging row update and count
	always_comb begin
		age_row = rdata_q;
		old_cnt = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (old_v[w]) begin
				age_row[w*SW +: SW] = '0;
			end
			old_cnt = old_cnt + CW'(old_v[w]);
		end
		aged_sum = {1'b0, aged_q} + (mlt_pkg::AGED_W+1)'(old_cnt);
	end

	// Bucket memory, single write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[row] <= '0;
		end else if (cmd.sweep_step) begin
			mem[waddr_q] <= age_row;
		end else if (cmd.commit && op_we) begin
			mem[waddr_q] <= op_row;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
			waddr_q <= raddr;
		end
	end

	// Aged accumulator, saturating
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			aged_q <= '0;
		end else if (cmd.sweep_step) begin
			aged_q <= aged_sum[mlt_pkg::AGED_W] ? mlt_pkg::AGED_MAX
				: aged_sum[mlt_pkg::AGED_W-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.emit_sweep) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q   <= op_status;
			fport_q    <= op_port;
			aged_out_q <= '0;
		end else if (cmd.emit_sweep) begin
			status_q   <= mlt_pkg::ST_OK;
			fport_q    <= '0;
			aged_out_q <= aged_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = status_q;
	assign out_port   = fport_q;
	assign out_aged   = aged_out_q;

endmodule
